// ===== hdl/wcsa_pkg.sv =====
`default_nettype none

package wcsa_pkg;

  // Field widths of the request and result.
  localparam int MODE_W     = 2;
  localparam int ID_W       = 8;
  localparam int OFS_W      = 32;
  localparam int BCNT_W     = 13;
  localparam int STATUS_W   = 2;
  localparam int SLOT_OUT_W = 3;
  localparam int LEN_W      = 13;
  localparam int CFG_W      = 4;

  // Packed stream widths.
  localparam int IN_DATA_W  = 56;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 64;
  localparam int OUT_USER_W = 4;

  // Request modes.
  localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FREE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_NOTE  = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STS_NULL    = 2'd1;
  localparam logic [STATUS_W-1:0] STS_NO_SLOT = 2'd2;

  // Active slot count after reset.
  localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_req;
    logic scan_rd;
    logic pick_rd;
    logic commit;
  } wcsa_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_last;
  } wcsa_sts_t;

endpackage

`default_nettype wire

// ===== hdl/write_cache_slot_allocator_top.sv =====
// A request is handled in steps: a walk over the slot table through its single read port,
// one slot per cycle, then a drain step to fold in the last read, one pick read and one commit,
// after which the result is registered onto out_tvalid. A new request is taken only once
// the last one is committed, and the commit waits while an earlier result is stalled.
// Reset (rst_n low, synchronous) frees every slot at once and sets the active count
// to eight; there is no clearing pass, and a result waiting on the output is dropped.
`default_nettype none

module write_cache_slot_allocator_top #(
  parameter int SLOT_COUNT = 8,
  parameter int SLOT_BYTES = 4096
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_wr_en,
  input  wire logic [wcsa_pkg::CFG_W-1:0]          cfg_wr_data,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // file_id [7:0], file_offset [39:8], byte_count [52:40], zero [55:53]
  input  wire logic [wcsa_pkg::IN_DATA_W-1:0]      in_tdata,
  // mode [1:0]
  input  wire logic [wcsa_pkg::IN_USER_W-1:0]      in_tuser,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // slot [2:0], flush_owner [10:3], flush_base [42:11], flush_length [55:43],
  // evicted_owner [63:56]
  output logic [wcsa_pkg::OUT_DATA_W-1:0]          out_tdata,
  // status [1:0], flush_valid [2], evicted_valid [3]
  output logic [wcsa_pkg::OUT_USER_W-1:0]          out_tuser
);
  import wcsa_pkg::*;

  wcsa_cmd_t              cmd;
  wcsa_sts_t              sts;
  logic [STATUS_W-1:0]    res_status;
  logic [SLOT_OUT_W-1:0]  res_slot;
  logic                   res_flush_valid;
  logic [ID_W-1:0]        res_flush_owner;
  logic [OFS_W-1:0]       res_flush_base;
  logic [LEN_W-1:0]       res_flush_length;
  logic                   res_evicted_valid;
  logic [ID_W-1:0]        res_evicted_owner;

  // Request and result sequencing.
  wcsa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  // Slot table, scan trackers and result register.
  wcsa_dp #(
    .SLOT_COUNT (SLOT_COUNT),
    .SLOT_BYTES (SLOT_BYTES)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_mode           (in_tuser[1:0]),
    .in_file_id        (in_tdata[7:0]),
    .in_file_offset    (in_tdata[39:8]),
    .in_byte_count     (in_tdata[52:40]),
    .out_status        (res_status),
    .out_slot          (res_slot),
    .out_flush_valid   (res_flush_valid),
    .out_flush_owner   (res_flush_owner),
    .out_flush_base    (res_flush_base),
    .out_flush_length  (res_flush_length),
    .out_evicted_valid (res_evicted_valid),
    .out_evicted_owner (res_evicted_owner)
  );

  // Pack the result onto the output stream.
  assign out_tdata = {res_evicted_owner, res_flush_length, res_flush_base,
                      res_flush_owner, res_slot};
  assign out_tuser = {res_evicted_valid, res_flush_valid, res_status};

endmodule

`default_nettype wire

// ===== hdl/wcsa_ctrl.sv =====
`default_nettype none

module wcsa_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  output wcsa_pkg::wcsa_cmd_t      cmd,
  input  wire wcsa_pkg::wcsa_sts_t sts
);
  import wcsa_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_PICK,
    ST_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // Handshake and command decode from the current state.
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_free   = !out_valid_r || out_tready;

  always_comb begin
    cmd          = '0;
    cmd.load_req = in_tvalid && in_tready;
    cmd.scan_rd  = (state_r == ST_SCAN);
    cmd.pick_rd  = (state_r == ST_PICK);
    cmd.commit   = (state_r == ST_FINISH) && out_free;
  end

  // Next state: walk the slot table, settle the pick, then hand over the result.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd.load_req) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts.scan_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_nxt = ST_PICK;
      end
      ST_PICK: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // The result stays valid until the consumer takes it.
  always_comb begin
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // An accepted request always starts the table walk.
  a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_req |=> state_r == ST_SCAN)
    else $error("request accepted without starting the scan");

  // A committed result shows up on the output in the next cycle.
  a_commit_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("committed result not presented");

  // A finished request waits while an earlier result is still stalled.
  a_finish_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH) && out_valid_r && !out_tready |=> state_r == ST_FINISH)
    else $error("result committed over a stalled one");

endmodule

`default_nettype wire

// ===== hdl/wcsa_dp.sv =====
`default_nettype none

module wcsa_dp #(
  parameter int SLOT_COUNT = 8,
  parameter int SLOT_BYTES = 4096
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire wcsa_pkg::wcsa_cmd_t              cmd,
  output wcsa_pkg::wcsa_sts_t                   sts,
  input  wire logic                             cfg_wr_en,
  input  wire logic [wcsa_pkg::CFG_W-1:0]       cfg_wr_data,
  input  wire logic [wcsa_pkg::MODE_W-1:0]      in_mode,
  input  wire logic [wcsa_pkg::ID_W-1:0]        in_file_id,
  input  wire logic [wcsa_pkg::OFS_W-1:0]       in_file_offset,
  input  wire logic [wcsa_pkg::BCNT_W-1:0]      in_byte_count,
  output logic [wcsa_pkg::STATUS_W-1:0]         out_status,
  output logic [wcsa_pkg::SLOT_OUT_W-1:0]       out_slot,
  output logic                                  out_flush_valid,
  output logic [wcsa_pkg::ID_W-1:0]             out_flush_owner,
  output logic [wcsa_pkg::OFS_W-1:0]            out_flush_base,
  output logic [wcsa_pkg::LEN_W-1:0]            out_flush_length,
  output logic                                  out_evicted_valid,
  output logic [wcsa_pkg::ID_W-1:0]             out_evicted_owner
);
  import wcsa_pkg::*;

  localparam int SW     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int FILL_W = $clog2(SLOT_BYTES + 1);
  localparam int SUM_W  = ((FILL_W > BCNT_W) ? FILL_W : BCNT_W) + 1;
  localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
  localparam int LIM_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  typedef enum logic [1:0] {
    PK_OWN,
    PK_FREE,
    PK_CLEAN,
    PK_FULL
  } pick_kind_t;

  // Configuration and the active slot limit.
  logic [CFG_W-1:0]  cfg_r;
  logic [LIM_W-1:0]  limit;

  // Latched request.
  logic [MODE_W-1:0] mode_r;
  logic [ID_W-1:0]   id_r;
  logic [OFS_W-1:0]  ofs_r;
  logic [BCNT_W-1:0] bcnt_r;

  // Slot table.
  logic [SLOT_COUNT-1:0] owned_r;
  logic [SLOT_COUNT-1:0] dirty_r;
  logic [ID_W-1:0]       owner_r [SLOT_COUNT];
  logic [OFS_W-1:0]      base_r  [SLOT_COUNT];
  logic [FILL_W-1:0]     fill_r  [SLOT_COUNT];

  // Table read port.
  logic [SW-1:0]     scan_idx_r;
  logic [SW-1:0]     rd_addr;
  logic [SW-1:0]     rd_idx_r;
  logic              rd_scan_r;
  logic              rd_owned_r;
  logic              rd_dirty_r;
  logic [ID_W-1:0]   rd_owner_r;
  logic [OFS_W-1:0]  rd_base_r;
  logic [FILL_W-1:0] rd_fill_r;

  // Scan trackers.
  logic              in_act;
  logic              own_found_r;
  logic [SW-1:0]     own_idx_r;
  logic              free_found_r;
  logic [SW-1:0]     free_idx_r;
  logic              clean_found_r;
  logic [SW-1:0]     clean_idx_r;
  logic [FILL_W-1:0] best_fill_r;
  logic [SW-1:0]     best_idx_r;

  // Pick and result.
  logic [SW-1:0]     pick_idx_nxt, pick_idx_r;
  pick_kind_t        pick_kind_nxt, pick_kind_r;
  logic              req_live;
  logic              ok;
  logic              alloc_wr;
  logic              free_wr;
  logic              note_wr;
  logic              flush_nxt;
  logic              evict_nxt;
  logic [STATUS_W-1:0] status_nxt;
  logic [SUM_W-1:0]  fill_sum;
  logic [FILL_W-1:0] fill_sat;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_wr_en) begin
      cfg_r <= cfg_wr_data;
    end
  end

  // Clamp the active count to one up to the built slot count.
  always_comb begin
    if (cfg_r == '0) begin
      limit = LIM_W'(1);
    end else if (LIM_W'(cfg_r) > LIM_W'(SLOT_COUNT)) begin
      limit = LIM_W'(SLOT_COUNT);
    end else begin
      limit = LIM_W'(cfg_r);
    end
  end

  // Capture the request at acceptance.
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      mode_r <= in_mode;
      id_r   <= in_file_id;
      ofs_r  <= in_file_offset;
      bcnt_r <= in_byte_count;
    end
  end

  // Scan address counter, one slot per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r <= '0;
    end else if (cmd.load_req) begin
      scan_idx_r <= '0;
    end else if (cmd.scan_rd) begin
      scan_idx_r <= scan_idx_r + SW'(1);
    end
  end

  assign sts.scan_last = (scan_idx_r == SW'(SLOT_COUNT - 1));
  assign rd_addr       = cmd.pick_rd ? pick_idx_nxt : scan_idx_r;

  // Registered read of one slot entry.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_scan_r <= 1'b0;
    end else begin
      rd_scan_r <= cmd.scan_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_rd || cmd.pick_rd) begin
      rd_idx_r   <= rd_addr;
      rd_owned_r <= owned_r[rd_addr];
      rd_dirty_r <= dirty_r[rd_addr];
      rd_owner_r <= owner_r[rd_addr];
      rd_base_r  <= base_r[rd_addr];
      rd_fill_r  <= fill_r[rd_addr];
    end
  end

  // Fold each scanned entry into the owner, free, clean and fullest trackers.
  assign in_act = (LIM_W'(rd_idx_r) < limit);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_found_r   <= 1'b0;
      free_found_r  <= 1'b0;
      clean_found_r <= 1'b0;
      own_idx_r     <= '0;
      free_idx_r    <= '0;
      clean_idx_r   <= '0;
      best_fill_r   <= '0;
      best_idx_r    <= '0;
    end else if (cmd.load_req) begin
      own_found_r   <= 1'b0;
      free_found_r  <= 1'b0;
      clean_found_r <= 1'b0;
      best_fill_r   <= '0;
      best_idx_r    <= '0;
    end else if (rd_scan_r) begin
      if (!own_found_r && rd_owned_r && (rd_owner_r == id_r)) begin
        own_found_r <= 1'b1;
        own_idx_r   <= rd_idx_r;
      end
      if (!free_found_r && in_act && !rd_owned_r) begin
        free_found_r <= 1'b1;
        free_idx_r   <= rd_idx_r;
      end
      if (!clean_found_r && in_act && (!rd_dirty_r || (rd_fill_r == '0))) begin
        clean_found_r <= 1'b1;
        clean_idx_r   <= rd_idx_r;
      end
      if (in_act && (rd_fill_r > best_fill_r)) begin
        best_fill_r <= rd_fill_r;
        best_idx_r  <= rd_idx_r;
      end
    end
  end

  // Choose the target slot in order of preference.
  always_comb begin
    if (own_found_r) begin
      pick_idx_nxt  = own_idx_r;
      pick_kind_nxt = PK_OWN;
    end else if (free_found_r) begin
      pick_idx_nxt  = free_idx_r;
      pick_kind_nxt = PK_FREE;
    end else if (clean_found_r) begin
      pick_idx_nxt  = clean_idx_r;
      pick_kind_nxt = PK_CLEAN;
    end else begin
      pick_idx_nxt  = best_idx_r;
      pick_kind_nxt = PK_FULL;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pick_rd) begin
      pick_idx_r  <= pick_idx_nxt;
      pick_kind_r <= pick_kind_nxt;
    end
  end

  // Result decode from the picked entry.
  assign req_live = (mode_r == MODE_ALLOC) || (mode_r == MODE_FREE) || (mode_r == MODE_NOTE);
  assign ok       = req_live && (id_r != '0) && ((mode_r == MODE_ALLOC) || own_found_r);
  assign alloc_wr = ok && (mode_r == MODE_ALLOC) && (pick_kind_r != PK_OWN);
  assign free_wr  = ok && (mode_r == MODE_FREE);
  assign note_wr  = ok && (mode_r == MODE_NOTE);
  assign evict_nxt = alloc_wr && ((pick_kind_r == PK_CLEAN) || (pick_kind_r == PK_FULL));
  assign flush_nxt = (alloc_wr && (pick_kind_r == PK_FULL)) ||
                     (free_wr && rd_dirty_r && (rd_fill_r != '0));

  always_comb begin
    if (!req_live) begin
      status_nxt = STS_OK;
    end else if (id_r == '0) begin
      status_nxt = STS_NULL;
    end else if ((mode_r != MODE_ALLOC) && !own_found_r) begin
      status_nxt = STS_NO_SLOT;
    end else begin
      status_nxt = STS_OK;
    end
  end

  // Saturating fill update for a write note.
  assign fill_sum = SUM_W'(rd_fill_r) + SUM_W'(bcnt_r);
  assign fill_sat = (fill_sum > SUM_W'(SLOT_BYTES)) ? FILL_W'(SLOT_BYTES) : FILL_W'(fill_sum);

  // Slot table flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owned_r <= '0;
      dirty_r <= '0;
    end else if (cmd.commit) begin
      if (alloc_wr) begin
        owned_r[pick_idx_r] <= 1'b1;
        dirty_r[pick_idx_r] <= 1'b0;
      end else if (free_wr) begin
        owned_r[pick_idx_r] <= 1'b0;
        dirty_r[pick_idx_r] <= 1'b0;
      end else if (note_wr) begin
        dirty_r[pick_idx_r] <= 1'b1;
      end
    end
  end

  // Slot table payload; the payload of an entry without an owner never decides a result.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (alloc_wr) begin
        owner_r[pick_idx_r] <= id_r;
        base_r[pick_idx_r]  <= ofs_r;
        fill_r[pick_idx_r]  <= '0;
      end else if (free_wr) begin
        fill_r[pick_idx_r]  <= '0;
      end else if (note_wr) begin
        fill_r[pick_idx_r]  <= fill_sat;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status        <= status_nxt;
      out_slot          <= ok ? SLOT_OUT_W'(pick_idx_r) : '0;
      out_flush_valid   <= flush_nxt;
      out_flush_owner   <= flush_nxt ? rd_owner_r : '0;
      out_flush_base    <= flush_nxt ? rd_base_r : '0;
      out_flush_length  <= flush_nxt ? LEN_W'(rd_fill_r) : '0;
      out_evicted_valid <= evict_nxt;
      out_evicted_owner <= evict_nxt ? rd_owner_r : '0;
    end
  end

  // A free slot that is picked lies inside the active range.
  a_free_active: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && alloc_wr && (pick_kind_r == PK_FREE) |-> LIM_W'(free_idx_r) < limit)
    else $error("free slot picked outside the active range");

  // Only an owned slot is ever flushed.
  a_flush_owned: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && flush_nxt |-> rd_owned_r)
    else $error("flush requested for a slot with no owner");

  // An allocation leaves its slot owned.
  a_alloc_owned: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && alloc_wr |=> owned_r[$past(pick_idx_r)])
    else $error("allocated slot not marked owned");

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wcsa_pkg::*;

  localparam int SLOTS    = 8;
  localparam int SLOT_CAP = 4096;

  // The one mode value that the block ignores.
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [ID_W-1:0]   file_id;
    logic [OFS_W-1:0]  file_offset;
    logic [BCNT_W-1:0] byte_count;
  } slot_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [SLOT_OUT_W-1:0] slot;
    logic                  flush_valid;
    logic [ID_W-1:0]       flush_owner;
    logic [OFS_W-1:0]      flush_base;
    logic [LEN_W-1:0]      flush_length;
    logic                  evicted_valid;
    logic [ID_W-1:0]       evicted_owner;
  } slot_reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [CFG_W-1:0] cfg_wr_data = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic [IN_USER_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b1;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;

  // Shadow copy of the slot table and the active count register.
  logic             sl_owned [SLOTS];
  logic [ID_W-1:0]  sl_owner [SLOTS];
  logic [OFS_W-1:0] sl_base  [SLOTS];
  logic [LEN_W-1:0] sl_fill  [SLOTS];
  logic             sl_dirty [SLOTS];
  logic [CFG_W-1:0] active_cfg;

  slot_req_t   pending_reqs[$];
  slot_reply_t slot_replies_due[$];

  bit req_taken = 1'b0;
  bit idle_on = 1'b1;
  int gap_left = 0;
  int stall_left = 0;
  int mismatch_count = 0;
  int requests_taken = 0;
  int replies_checked = 0;
  int flushes_seen = 0;
  int evictions_seen = 0;
  int no_slot_seen = 0;

  write_cache_slot_allocator_top #(
    .SLOT_COUNT(SLOTS),
    .SLOT_BYTES(SLOT_CAP)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  always #2 clk = ~clk;

  function automatic void clear_slot_entry(int s);
    sl_owned[s] = 1'b0;
    sl_owner[s] = '0;
    sl_base[s]  = '1;
    sl_fill[s]  = '0;
    sl_dirty[s] = 1'b0;
  endfunction

  // Applies one request to the shadow table and returns the reply it should get.
  function automatic slot_reply_t apply_slot_request(slot_req_t r);
    slot_reply_t rep;
    int n;
    int owner_at;
    int pick;
    int sum;
    rep = '0;
    n = (active_cfg == 0) ? 1 : ((active_cfg > SLOTS) ? SLOTS : int'(active_cfg));
    if (r.mode == MODE_UNUSED) return rep;
    if (r.file_id == '0) begin
      rep.status = STS_NULL;
      return rep;
    end
    // Ownership lookup spans every slot, active or not.
    owner_at = -1;
    for (int s = SLOTS - 1; s >= 0; s--)
      if (sl_owned[s] && sl_owner[s] == r.file_id) owner_at = s;

    if (r.mode == MODE_ALLOC) begin
      if (owner_at >= 0) begin
        rep.slot = owner_at[SLOT_OUT_W-1:0];
        return rep;
      end
      pick = -1;
      for (int s = n - 1; s >= 0; s--)
        if (!sl_owned[s]) pick = s;
      if (pick < 0) begin
        // No free slot: take the first clean or empty one, else the fullest.
        for (int s = n - 1; s >= 0; s--)
          if (!sl_dirty[s] || sl_fill[s] == 0) pick = s;
        if (pick < 0) begin
          pick = 0;
          for (int s = 1; s < n; s++)
            if (sl_fill[s] > sl_fill[pick]) pick = s;
          rep.flush_valid  = 1'b1;
          rep.flush_owner  = sl_owner[pick];
          rep.flush_base   = sl_base[pick];
          rep.flush_length = sl_fill[pick];
        end
        rep.evicted_valid = 1'b1;
        rep.evicted_owner = sl_owner[pick];
      end
      sl_owned[pick] = 1'b1;
      sl_owner[pick] = r.file_id;
      sl_base[pick]  = r.file_offset;
      sl_fill[pick]  = '0;
      sl_dirty[pick] = 1'b0;
      rep.slot = pick[SLOT_OUT_W-1:0];
      return rep;
    end

    if (owner_at < 0) begin
      rep.status = STS_NO_SLOT;
      return rep;
    end
    rep.slot = owner_at[SLOT_OUT_W-1:0];
    if (r.mode == MODE_FREE) begin
      if (sl_dirty[owner_at] && sl_fill[owner_at] > 0) begin
        rep.flush_valid  = 1'b1;
        rep.flush_owner  = sl_owner[owner_at];
        rep.flush_base   = sl_base[owner_at];
        rep.flush_length = sl_fill[owner_at];
      end
      clear_slot_entry(owner_at);
    end else begin
      sum = sl_fill[owner_at] + r.byte_count;
      if (sum > SLOT_CAP) sum = SLOT_CAP;
      sl_fill[owner_at]  = sum[LEN_W-1:0];
      sl_dirty[owner_at] = 1'b1;
    end
    return rep;
  endfunction

  // Random request over a small pool of handles so that most requests hit owned slots.
  function automatic slot_req_t random_slot_request(int id_span);
    slot_req_t r;
    int k;
    k = $urandom_range(0, 99);
    if (k < 35) r.mode = MODE_ALLOC;
    else if (k < 50) r.mode = MODE_FREE;
    else if (k < 92) r.mode = MODE_NOTE;
    else if (k < 96) r.mode = MODE_UNUSED;
    else r.mode = MODE_W'($urandom_range(0, 3));
    k = $urandom_range(0, 99);
    if (k < 88) r.file_id = ID_W'($urandom_range(1, id_span));
    else if (k < 92) r.file_id = '0;
    else r.file_id = ID_W'($urandom_range(0, 255));
    k = $urandom_range(0, 19);
    if (k == 0) r.file_offset = '0;
    else if (k == 1) r.file_offset = '1;
    else r.file_offset = $urandom;
    k = $urandom_range(0, 99);
    if (k < 70) r.byte_count = BCNT_W'($urandom_range(1, 1500));
    else if (k < 80) r.byte_count = '0;
    else if (k < 88) r.byte_count = BCNT_W'($urandom_range(0, 8191));
    else if (k < 94) r.byte_count = BCNT_W'(SLOT_CAP);
    else r.byte_count = '1;
    return r;
  endfunction

  task automatic queue_req(logic [MODE_W-1:0] mode, logic [ID_W-1:0] id,
                           logic [OFS_W-1:0] ofs, logic [BCNT_W-1:0] cnt);
    slot_req_t r;
    r.mode = mode;
    r.file_id = id;
    r.file_offset = ofs;
    r.byte_count = cnt;
    pending_reqs.push_back(r);
  endtask

  // Waits until every request has been sent and answered, then lets the block settle.
  task automatic wait_for_drain();
    while (pending_reqs.size() != 0 || in_tvalid || slot_replies_due.size() != 0)
      @(negedge clk);
    repeat (SLOTS + 8) @(negedge clk);
  endtask

  task automatic set_active_slots(logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic run_random_phase(logic [CFG_W-1:0] value, int count, int id_span);
    set_active_slots(value);
    @(posedge clk);
    repeat (count) pending_reqs.push_back(random_slot_request(id_span));
    wait_for_drain();
  endtask

  // Request driver: holds a request until taken, with random gaps between requests.
  always @(negedge clk) begin
    if (!in_tvalid || req_taken) begin
      if (idle_on && gap_left > 0) begin
        in_tvalid <= 1'b0;
        gap_left--;
      end else if (pending_reqs.size() != 0) begin
        slot_req_t r;
        r = pending_reqs.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= {3'b000, r.byte_count, r.file_offset, r.file_id};
        in_tuser <= r.mode;
        if ($urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 14);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result stalls come in bursts.
  always @(negedge clk) begin
    if (!idle_on || stall_left == 0) begin
      out_tready <= 1'b1;
      if (idle_on && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 14);
    end else begin
      out_tready <= 1'b0;
      stall_left--;
    end
  end

  // Tracks reset, register writes and accepted requests in the shadow table.
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < SLOTS; s++) clear_slot_entry(s);
      active_cfg = CFG_RESET;
      req_taken = 1'b0;
    end else begin
      slot_req_t r;
      if (cfg_wr_en) active_cfg = cfg_wr_data;
      req_taken = in_tvalid && in_tready;
      if (req_taken) begin
        r.mode = in_tuser;
        r.file_id = in_tdata[7:0];
        r.file_offset = in_tdata[39:8];
        r.byte_count = in_tdata[52:40];
        slot_replies_due.push_back(apply_slot_request(r));
        requests_taken++;
      end
    end
  end

  // Result monitor: compares each accepted result with the oldest expected reply.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      slot_reply_t got;
      slot_reply_t want;
      got.status        = out_tuser[1:0];
      got.flush_valid   = out_tuser[2];
      got.evicted_valid = out_tuser[3];
      got.slot          = out_tdata[2:0];
      got.flush_owner   = out_tdata[10:3];
      got.flush_base    = out_tdata[42:11];
      got.flush_length  = out_tdata[55:43];
      got.evicted_owner = out_tdata[63:56];
      if (slot_replies_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("ERROR %0t: result with no request outstanding: tuser=%h tdata=%h",
                   $realtime, out_tuser, out_tdata);
      end else begin
        want = slot_replies_due.pop_front();
        replies_checked++;
        if (want.flush_valid) flushes_seen++;
        if (want.evicted_valid) evictions_seen++;
        if (want.status == STS_NO_SLOT) no_slot_seen++;
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("ERROR %0t: result %0d mismatch", $realtime, replies_checked);
            $display("  expected sts=%0d slot=%0d flush=%b/%h/%h/%0d evict=%b/%h",
                     want.status, want.slot, want.flush_valid, want.flush_owner,
                     want.flush_base, want.flush_length, want.evicted_valid,
                     want.evicted_owner);
            $display("  actual   sts=%0d slot=%0d flush=%b/%h/%h/%0d evict=%b/%h",
                     got.status, got.slot, got.flush_valid, got.flush_owner,
                     got.flush_base, got.flush_length, got.evicted_valid,
                     got.evicted_owner);
          end
        end
      end
    end
  end

  // Stimulus sequence.
  initial begin
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Null handles in every mode, the unused mode, and requests from a file with no slot.
    queue_req(MODE_ALLOC, 8'd0, '1, '1);
    queue_req(MODE_FREE, 8'd0, '0, '0);
    queue_req(MODE_NOTE, 8'd0, 32'h1234_5678, 13'd100);
    queue_req(MODE_UNUSED, 8'hFF, '1, '1);
    queue_req(MODE_FREE, 8'd9, '0, '0);
    // Fill the whole pool, then re-request an owned slot.
    queue_req(MODE_ALLOC, 8'd1, '0, '0);
    queue_req(MODE_ALLOC, 8'd2, '1, '1);
    for (int i = 3; i <= 8; i++) queue_req(MODE_ALLOC, i[7:0], i * 32'h1001_0000, '0);
    queue_req(MODE_ALLOC, 8'd1, 32'h0000_0123, '0);
    // Saturating fills and a dirty slot holding no data.
    queue_req(MODE_NOTE, 8'd1, '0, '1);
    queue_req(MODE_NOTE, 8'd2, '0, 13'd4096);
    queue_req(MODE_NOTE, 8'd3, '0, '0);
    // Eviction without a flush takes the empty dirty slot.
    queue_req(MODE_ALLOC, 8'd200, 32'h8000_0000, '0);
    // Make every slot dirty with data so the next allocate must flush the fullest.
    queue_req(MODE_NOTE, 8'd200, '0, 13'd10);
    queue_req(MODE_NOTE, 8'd4, '0, 13'd300);
    queue_req(MODE_NOTE, 8'd5, '0, 13'd4095);
    queue_req(MODE_NOTE, 8'd6, '0, 13'd2);
    queue_req(MODE_NOTE, 8'd7, '0, 13'd4096);
    queue_req(MODE_NOTE, 8'd8, '0, 13'd700);
    queue_req(MODE_ALLOC, 8'd255, 32'hDEAD_BEEF, '0);
    // Free a dirty slot with data, then a clean one.
    queue_req(MODE_FREE, 8'd2, '0, '0);
    queue_req(MODE_FREE, 8'd255, '0, '0);
    wait_for_drain();

    // Random traffic across several active slot counts, out-of-range values included.
    run_random_phase(4'd3, 250, 6);
    run_random_phase(4'd1, 150, 4);
    run_random_phase(4'd0, 100, 3);
    run_random_phase(4'd15, 250, 14);
    run_random_phase(4'd5, 250, 10);
    @(posedge clk);
    idle_on = 1'b0;
    run_random_phase(4'd8, 325, 12);

    $display("Checked %0d results for %0d requests over active counts 8, 3, 1, 0, 15, 5, 8.",
             replies_checked, requests_taken);
    $display("Saw %0d flushes, %0d evictions and %0d requests from files without a slot.",
             flushes_seen, evictions_seen, no_slot_seen);
    if (mismatch_count == 0 && slot_replies_due.size() == 0) begin
      $display("write_cache_slot_allocator_top verification clean");
    end else begin
      $display("write_cache_slot_allocator_top verification failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2_000_000;
    $display("write_cache_slot_allocator_top verification failed");
    $finish;
  end

endmodule
